[rtl/nfa_pkg.sv]
// Shared constants, codes and types for the NFA set simulator.
package nfa_pkg;

    localparam int NUM_STATES  = 32;
    localparam int NUM_SYMBOLS = 256;

    localparam int STATE_W    = $clog2(NUM_STATES);
    localparam int SYM_W      = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W     = STATE_W + SYM_W;
    localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;

    // Fixed widths of the port fields
    localparam int OP_W          = 2;
    localparam int STATE_FIELD_W = 5;
    localparam int SYM_FIELD_W   = 8;
    localparam int MASK_W        = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    // Input queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_FEED     = 2'd1,
        OP_END      = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_EDGE,
        K_FEED,
        K_FEED_EMPTY,
        K_END,
        K_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   symbol;
    } item_t;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_EDGE_RD,
        B_EDGE_WR,
        B_SCAN,
        B_DRAIN,
        B_REPORT
    } back_state_t;

    typedef logic [NUM_STATES-1:0] set_t;

endpackage

[rtl/nfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nfa_front.sv]
// Front end: accepts input transactions, classifies them and queues them for the back end.
module nfa_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enable,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nfa_pkg::OP_W-1:0]          operation,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] from_state,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] to_state,
    input  logic [nfa_pkg::SYM_FIELD_W-1:0]   symbol,
    output logic                              head_valid,
    output nfa_pkg::item_t                    head,
    input  logic                              pop
);
    import nfa_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    item_t             item_in;
    logic              push;
    logic              edge_ok;
    logic              sym_ok;

    // Classify: out-of-range edges become no-ops, out-of-range symbols empty the set
    always_comb
    begin
        edge_ok = (int'(from_state) < NUM_STATES) && (int'(to_state) < NUM_STATES) &&
                  (int'(symbol) < NUM_SYMBOLS);
        sym_ok  = int'(symbol) < NUM_SYMBOLS;
        item_in.from_state = STATE_W'(from_state);
        item_in.to_state   = STATE_W'(to_state);
        item_in.symbol     = SYM_W'(symbol);
        case (op_t'(operation))
            OP_ADD_EDGE: item_in.kind = edge_ok ? K_EDGE : K_NOP;
            OP_FEED:     item_in.kind = sym_ok ? K_FEED : K_FEED_EMPTY;
            OP_END:      item_in.kind = K_END;
            OP_CLEAR:    item_in.kind = K_CLEAR;
            default:     item_in.kind = K_NOP;
        endcase
    end

    assign in_ready   = enable && (int'(count_reg) < QUEUE_DEPTH);
    assign push       = in_valid && in_ready;
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[rtl/nfa_back.sv]
// Back end: edge table, active state set, string sequencing and result register.
module nfa_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           head_valid,
    input  nfa_pkg::item_t                 head,
    output logic                           pop,
    output logic                           init_done,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic [nfa_pkg::MASK_W-1:0]     state_mask
);
    import nfa_pkg::*;

    back_state_t              state_reg, state_next;
    item_t                    item_reg, item_next;
    set_t                     active_reg, active_next;
    set_t                     acc_reg, acc_next;
    logic                     open_reg, open_next;
    logic                     hit_reg, hit_next;
    logic [STATE_W-1:0]       scan_reg, scan_next;
    logic [ADDR_W-1:0]        sweep_reg, sweep_next;
    logic                     init_reg, init_next;
    logic [STATE_FIELD_W-1:0] start_reg;
    logic [MASK_W-1:0]        accept_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     accepted_reg, accepted_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [NUM_STATES-1:0]    wdata;
    logic [ADDR_W-1:0]        raddr;
    logic [NUM_STATES-1:0]    rdata;
    set_t                     start_bit;
    set_t                     seed;
    set_t                     hits;
    logic                     out_free;

    nfa_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (TABLE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign start_bit = (int'(start_reg) < NUM_STATES) ?
                       (set_t'(1) << STATE_W'(start_reg)) : '0;
    assign seed      = open_reg ? active_reg : start_bit;
    assign hits      = active_reg & set_t'(accept_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == B_IDLE) && head_valid;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        active_next    = active_reg;
        acc_next       = acc_reg;
        open_next      = open_reg;
        hit_next       = hit_reg;
        scan_next      = scan_reg;
        sweep_next     = sweep_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg && !out_ready;
        accepted_next  = accepted_reg;
        mask_next      = mask_reg;
        we             = 1'b0;
        waddr          = {item_reg.from_state, item_reg.symbol};
        wdata          = rdata | (set_t'(1) << item_reg.to_state);
        raddr          = {item_reg.from_state, item_reg.symbol};

        case (state_reg)
            B_SWEEP:
            begin
                we         = 1'b1;
                waddr      = sweep_reg;
                wdata      = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    init_next  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (head_valid)
                begin
                    item_next = head;
                    case (head.kind)
                        K_EDGE:
                        begin
                            state_next = B_EDGE_RD;
                        end
                        K_FEED:
                        begin
                            active_next = seed;
                            open_next   = 1'b1;
                            acc_next    = '0;
                            hit_next    = 1'b0;
                            scan_next   = '0;
                            state_next  = B_SCAN;
                        end
                        K_FEED_EMPTY:
                        begin
                            active_next = '0;
                            open_next   = 1'b1;
                        end
                        K_END:
                        begin
                            active_next = seed;
                            state_next  = B_REPORT;
                        end
                        K_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = B_SWEEP;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_EDGE_RD:
            begin
                state_next = B_EDGE_WR;
            end
            B_EDGE_WR:
            begin
                // Read-modify-write: OR the destination into the row
                we         = 1'b1;
                state_next = B_IDLE;
            end
            B_SCAN:
            begin
                // Read one row per state; the previous row lands this cycle
                raddr     = {scan_reg, item_reg.symbol};
                hit_next  = active_reg[scan_reg];
                acc_next  = acc_reg | (hit_reg ? rdata : '0);
                scan_next = scan_reg + 1'b1;
                if (scan_reg == STATE_W'(NUM_STATES - 1))
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                active_next = acc_reg | (hit_reg ? rdata : '0);
                state_next  = B_IDLE;
            end
            B_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = hits != '0;
                    mask_next      = (hits != '0) ? MASK_W'(hits) : MASK_W'(active_reg);
                    active_next    = '0;
                    open_next      = 1'b0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            active_reg    <= '0;
            open_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            scan_reg      <= '0;
            sweep_reg     <= '0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            accept_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            open_reg      <= open_next;
            hit_reg       <= hit_next;
            scan_reg      <= scan_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == CFG_START_STATE)
            begin
                start_reg <= cfg_data[STATE_FIELD_W-1:0];
            end
            if (cfg_write && cfg_index == CFG_ACCEPT_MASK)
            begin
                accept_reg <= cfg_data[MASK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        accepted_reg <= accepted_next;
        mask_reg     <= mask_next;
    end

    assign init_done  = init_reg;
    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign state_mask = mask_reg;

endmodule

[rtl/nfa_set_simulator.sv]
// Top level of the NFA set simulator: front end, input queue and back end.
//
// Simulates an NFA without epsilon moves over 32 states and 256 symbols. After reset the
// edge table memory is swept to zero, one row a cycle, during which no transaction is
// accepted; a clear-table operation runs the same sweep. An add edge is a read-modify-write
// of one table row, an end of string may wait for the result register to drain, and a feed
// symbol scans every state: the table has a single read port, so one destination row is
// read per state. A two-entry queue sits between the front end and the sequencer, and a
// result register on the output lets the next string proceed while a result waits.
// Configuration may be written only while idle.
module nfa_set_simulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [nfa_pkg::OP_W-1:0]          operation,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] from_state,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] to_state,
    input  logic [nfa_pkg::SYM_FIELD_W-1:0]   symbol,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic [nfa_pkg::MASK_W-1:0]     state_mask,
    input  logic                           cfg_write,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nfa_pkg::*;

    logic  head_valid;
    item_t head;
    logic  pop;
    logic  init_done;

    nfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (init_done),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .from_state (from_state),
        .to_state   (to_state),
        .symbol     (symbol),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    nfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .init_done  (init_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .state_mask (state_mask)
    );

endmodule

[rtl/nfa_checker.sv]
// Port-level checker for the NFA set simulator, bound to the top level.
module nfa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [nfa_pkg::OP_W-1:0]          operation,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] from_state,
    input  logic [nfa_pkg::STATE_FIELD_W-1:0] to_state,
    input  logic [nfa_pkg::SYM_FIELD_W-1:0]   symbol,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           accepted,
    input  logic [nfa_pkg::MASK_W-1:0]     state_mask,
    input  logic                           cfg_write,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nfa_pkg::*;

    logic [MASK_W-1:0] accept_reg;
    logic              in_seen;

    // Shadow the accepting-state mask from configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_reg <= '0;
        end
        else if (cfg_write && cfg_index == CFG_ACCEPT_MASK)
        begin
            accept_reg <= cfg_data[MASK_W-1:0];
        end
    end

    assign in_seen = in_valid && in_ready && (operation != '0 || from_state != '0 ||
                     to_state != '0 || symbol != '0 || 1'b1);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(state_mask))
        else $error("result changed while stalled");

    // Accept reports a non-empty set of accepting states only
    a_accept_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> state_mask != '0 && (state_mask & ~accept_reg) == '0)
        else $error("accept with non-accepting or empty mask");

    // Reject never shows an accepting state
    a_reject_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (state_mask & accept_reg) == '0)
        else $error("reject with an accepting state in the mask");

    // No transaction is taken when reset is seen to rise, at the start of the sweep that follows
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_seen)
        else $error("input taken during reset sweep");

endmodule

bind nfa_set_simulator nfa_checker u_nfa_checker (.*);
